// ----- hw/rtl/prc_pkg.sv -----
// ----------------------------------------------------------------------------
// prc_pkg: shared types and control store of the PI-resonant controller
// Holds the item and configuration types, the control word layout and the
// microprogram that sequences one sample through the shared multiplier.
// ----------------------------------------------------------------------------
package prc_pkg;

  // Width of the wide accumulator: the resonant sum of four rounded products
  // needs about 50 bits, so two more give headroom for every sum formed.
  localparam int AccW  = 52;
  localparam int StepW = 4;
  localparam int CfgIdxW = 3;
  localparam int CfgDataW = 32;

  typedef logic [StepW-1:0] step_t;

  localparam step_t StepIdle = step_t'(0);

  // Register indexes of the configuration port.
  typedef enum logic [CfgIdxW-1:0] {
    REG_PROP_GAIN   = 3'd0,
    REG_INTEG_GAIN  = 3'd1,
    REG_INTEG_LIMIT = 3'd2,
    REG_OUT_UPPER   = 3'd3,
    REG_OUT_LOWER   = 3'd4,
    REG_RES_A1      = 3'd5,
    REG_RES_A2      = 3'd6,
    REG_RES_B0      = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    logic signed [31:0] target;
    logic signed [31:0] measured;
    logic signed [31:0] feedforward_term;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] drive;
    logic               clamped;
  } out_item_t;

  typedef struct packed {
    logic signed [31:0] prop_gain;
    logic signed [31:0] integ_gain;
    logic        [30:0] integ_limit;
    logic signed [31:0] out_upper;
    logic signed [31:0] out_lower;
    logic signed [31:0] res_a1;
    logic signed [31:0] res_a2;
    logic signed [31:0] res_b0;
  } prc_cfg_t;

  // Operand pair fed to the multiplier in a step.
  typedef enum logic [3:0] {
    MUL_NONE,
    MUL_E_SP,
    MUL_B0_E,
    MUL_B0_EP2,
    MUL_A1_RP1,
    MUL_A2_RP2,
    MUL_KP_E,
    MUL_KI_INT,
    MUL_WG_EXC
  } mul_sel_e;

  // Accumulator operation; q is the rounded product of the previous step.
  typedef enum logic [2:0] {
    ACC_HOLD,
    ACC_INT_Q,
    ACC_Q,
    ACC_ADD_Q,
    ACC_SUB_Q,
    ACC_RES_Q,
    ACC_ADD_FF,
    ACC_SUB_OUT
  } acc_op_e;

  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_CLAMP_INT,
    ACT_SHIFT_HIST,
    ACT_LIMIT_OUT,
    ACT_FINISH
  } act_e;

  typedef enum logic [1:0] {
    WAIT_NONE,
    WAIT_IN,
    WAIT_OUT
  } wait_e;

  typedef struct packed {
    mul_sel_e mul;
    acc_op_e  acc;
    act_e     act;
    wait_e    wt;
    logic     jump;
    step_t    tgt;
  } ucode_t;

  // Strobes from the sequencer to the datapath.
  typedef struct packed {
    mul_sel_e mul;
    acc_op_e  acc;
    act_e     act;
    logic     accept;
  } prc_ctl_t;

  // The microprogram. A product issued in one step is rounded and used in
  // the next step, by the accumulator or, for the last one, by the finish step.
  function automatic ucode_t prc_ucode(input step_t step);
    ucode_t uw;
    unique case (step)
      4'd0:    uw = '{MUL_NONE,   ACC_HOLD,    ACT_NONE,       WAIT_IN,   1'b0, StepIdle};
      4'd1:    uw = '{MUL_E_SP,   ACC_HOLD,    ACT_NONE,       WAIT_NONE, 1'b0, StepIdle};
      4'd2:    uw = '{MUL_B0_E,   ACC_INT_Q,   ACT_NONE,       WAIT_NONE, 1'b0, StepIdle};
      4'd3:    uw = '{MUL_B0_EP2, ACC_Q,       ACT_CLAMP_INT,  WAIT_NONE, 1'b0, StepIdle};
      4'd4:    uw = '{MUL_A1_RP1, ACC_ADD_Q,   ACT_NONE,       WAIT_NONE, 1'b0, StepIdle};
      4'd5:    uw = '{MUL_A2_RP2, ACC_SUB_Q,   ACT_NONE,       WAIT_NONE, 1'b0, StepIdle};
      4'd6:    uw = '{MUL_KP_E,   ACC_SUB_Q,   ACT_NONE,       WAIT_NONE, 1'b0, StepIdle};
      4'd7:    uw = '{MUL_KI_INT, ACC_RES_Q,   ACT_SHIFT_HIST, WAIT_NONE, 1'b0, StepIdle};
      4'd8:    uw = '{MUL_NONE,   ACC_ADD_Q,   ACT_NONE,       WAIT_NONE, 1'b0, StepIdle};
      4'd9:    uw = '{MUL_NONE,   ACC_ADD_FF,  ACT_NONE,       WAIT_NONE, 1'b0, StepIdle};
      4'd10:   uw = '{MUL_NONE,   ACC_HOLD,    ACT_LIMIT_OUT,  WAIT_NONE, 1'b0, StepIdle};
      4'd11:   uw = '{MUL_NONE,   ACC_SUB_OUT, ACT_NONE,       WAIT_NONE, 1'b0, StepIdle};
      4'd12:   uw = '{MUL_WG_EXC, ACC_HOLD,    ACT_NONE,       WAIT_NONE, 1'b0, StepIdle};
      4'd13:   uw = '{MUL_NONE,   ACC_HOLD,    ACT_FINISH,     WAIT_OUT,  1'b1, StepIdle};
      default: uw = '{MUL_NONE,   ACC_HOLD,    ACT_NONE,       WAIT_NONE, 1'b1, StepIdle};
    endcase
    return uw;
  endfunction

endpackage

// ----- hw/rtl/prc_stream_if.sv -----
// ----------------------------------------------------------------------------
// prc_stream_if: valid/ready channel
// Carries one item per accepted handshake; the payload type is set per use.
// ----------------------------------------------------------------------------
interface prc_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- hw/rtl/pi_resonant_controller.sv -----
// ----------------------------------------------------------------------------
// pi_resonant_controller: PI controller with resonant term and anti-windup
// Top level: configuration registers, microcode sequencer and datapath.
// ----------------------------------------------------------------------------
// Each input item carries a target, a measurement and a feedforward term in
// signed Q16.16 and yields exactly one result item with the drive value and a
// flag that tells whether the output limits were hit. The error is saturated
// to 32 bits; the integral grows by error times SAMPLE_PERIOD and is clamped
// to plus or minus integ_limit; a quasi-resonant filter computes
// b0*(e + e[n-2]) - a1*r[n-1] - a2*r[n-2]. The sum of the proportional,
// integral, resonant and feedforward terms is clamped to out_upper and
// out_lower (upper is tested first), and the excess times WINDUP_GAIN is
// taken off both the integral and the clamped output. Every product is
// rounded to nearest, with ties upward, and the stored results saturate.
// The next item is accepted only once the microprogram has run through for
// the last one, and the result is registered in its final step. The
// microprogram has 14 steps, one step to accept and thirteen to compute, and
// runs all eight products through one shared 32x32 multiplier, at most one
// product per step. The result sits in an output
// register, so the next item is accepted while an earlier result waits to be
// taken; only when a second result is ready and the first has still not been
// taken does the sequencer hold in its last step. Configuration registers are
// written through the plain write port and should be changed only while the
// block is idle. SAMPLE_PERIOD and WINDUP_GAIN are Q16.16 constants.
// ----------------------------------------------------------------------------
module pi_resonant_controller
  import prc_pkg::*;
#(
  parameter int unsigned SAMPLE_PERIOD = 3,
  parameter int unsigned WINDUP_GAIN   = 65536
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  prc_stream_if.sink          in_i,
  prc_stream_if.source        out_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i
);

  prc_cfg_t  cfg_q;
  prc_ctl_t  ctl;
  in_item_t  in_data;
  out_item_t out_data;

  // Configuration registers, all cleared by reset. The integral limit keeps
  // only the low 31 bits of the written word.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_PROP_GAIN:   cfg_q.prop_gain   <= cfg_wdata_i;
        REG_INTEG_GAIN:  cfg_q.integ_gain  <= cfg_wdata_i;
        REG_INTEG_LIMIT: cfg_q.integ_limit <= cfg_wdata_i[30:0];
        REG_OUT_UPPER:   cfg_q.out_upper   <= cfg_wdata_i;
        REG_OUT_LOWER:   cfg_q.out_lower   <= cfg_wdata_i;
        REG_RES_A1:      cfg_q.res_a1      <= cfg_wdata_i;
        REG_RES_A2:      cfg_q.res_a2      <= cfg_wdata_i;
        REG_RES_B0:      cfg_q.res_b0      <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  assign in_data = in_i.data;

  // The sequencer steps through the control store and hands one control word
  // per cycle to the datapath.
  prc_sequencer u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .ctl_o       (ctl)
  );

  // The datapath holds the shared multiplier, the accumulator, the integral
  // and the resonant history, and the output payload register.
  prc_datapath #(
    .SAMPLE_PERIOD (SAMPLE_PERIOD),
    .WINDUP_GAIN   (WINDUP_GAIN)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (ctl),
    .cfg_i      (cfg_q),
    .in_data_i  (in_data),
    .out_data_o (out_data)
  );

  assign out_o.data = out_data;

endmodule

// ----- hw/rtl/prc_sequencer.sv -----
// ----------------------------------------------------------------------------
// prc_sequencer: step counter and control store readout
// Walks the microprogram, holds on wait conditions, takes jumps and owns the
// valid flag of the output register.
// ----------------------------------------------------------------------------
module prc_sequencer
  import prc_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  logic     out_ready_i,
  output logic     out_valid_o,
  output prc_ctl_t ctl_o
);

  step_t  step_q, step_d;
  ucode_t uc;
  logic   hold;
  logic   out_valid_q, out_valid_d;

  assign uc = prc_ucode(step_q);

  always_comb begin
    unique case (uc.wt)
      WAIT_NONE: hold = 1'b0;
      WAIT_IN:   hold = !in_valid_i;
      WAIT_OUT:  hold = out_valid_q && !out_ready_i;
      default:   hold = 1'b0;
    endcase
  end

  always_comb begin
    if (hold) begin
      step_d = step_q;
    end else if (uc.jump) begin
      step_d = uc.tgt;
    end else begin
      step_d = step_q + 1'b1;
    end
  end

  assign in_ready_o   = (uc.wt == WAIT_IN);
  assign ctl_o.accept = in_ready_o && in_valid_i;
  assign ctl_o.mul    = hold ? MUL_NONE : uc.mul;
  assign ctl_o.acc    = hold ? ACC_HOLD : uc.acc;
  assign ctl_o.act    = hold ? ACT_NONE : uc.act;

  // A finished item refills the output register even while the old one is
  // being taken in the same cycle.
  assign out_valid_d = ((uc.act == ACT_FINISH) && !hold) || (out_valid_q && !out_ready_i);
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= StepIdle;
      out_valid_q <= 1'b0;
    end else begin
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ----- hw/rtl/prc_datapath.sv -----
// ----------------------------------------------------------------------------
// prc_datapath: shared multiplier, wide accumulator and controller state
// One signed 32x32 multiplier with a registered product, a rounding stage,
// a wide accumulator and the integral and resonant history registers.
// ----------------------------------------------------------------------------
module prc_datapath
  import prc_pkg::*;
#(
  parameter int unsigned SAMPLE_PERIOD = 3,
  parameter int unsigned WINDUP_GAIN   = 65536
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  prc_ctl_t  ctl_i,
  input  prc_cfg_t  cfg_i,
  input  in_item_t  in_data_i,
  output out_item_t out_data_o
);

  localparam int QW = 49;
  localparam logic signed [31:0] SpQ = 32'(SAMPLE_PERIOD);
  localparam logic signed [31:0] WgQ = 32'(WINDUP_GAIN);

  function automatic logic signed [31:0] sat32(input logic signed [AccW-1:0] v);
    logic [AccW-32:0] top_bits;
    top_bits = v[AccW-1:31];
    if ((top_bits == '0) || (top_bits == '1)) begin
      return 32'(v);
    end else if (v[AccW-1]) begin
      return 32'sh8000_0000;
    end else begin
      return 32'sh7fff_ffff;
    end
  endfunction

  logic signed [31:0]     err_q, ff_q, integ_q, outv_q;
  logic signed [31:0]     integral_q, ep1_q, ep2_q, rp1_q, rp2_q;
  logic signed [31:0]     integral_d, ep1_d, ep2_d, rp1_d, rp2_d;
  logic signed [31:0]     mul_a, mul_b, acc_sat, err_d;
  logic signed [63:0]     prod_q, prod_d, rnd;
  logic signed [QW-1:0]   q;
  logic signed [AccW-1:0] q_ext, acc_q, acc_d, lim_ext;
  logic signed [32:0]     diff;
  out_item_t              out_q, out_d;
  logic signed [31:0]     integ_d, outv_d;
  logic                   clamped_q, clamped_d;

  // Error with saturation, formed as the item is accepted.
  assign diff  = 33'(in_data_i.target) - 33'(in_data_i.measured);
  assign err_d = (diff[32] != diff[31]) ? (diff[32] ? 32'sh8000_0000 : 32'sh7fff_ffff)
                                        : 32'(diff);

  assign acc_sat = sat32(acc_q);

  always_comb begin
    unique case (ctl_i.mul)
      MUL_NONE:   begin mul_a = '0;              mul_b = '0;         end
      MUL_E_SP:   begin mul_a = err_q;           mul_b = SpQ;        end
      MUL_B0_E:   begin mul_a = cfg_i.res_b0;    mul_b = err_q;      end
      MUL_B0_EP2: begin mul_a = cfg_i.res_b0;    mul_b = ep2_q;      end
      MUL_A1_RP1: begin mul_a = cfg_i.res_a1;    mul_b = rp1_q;      end
      MUL_A2_RP2: begin mul_a = cfg_i.res_a2;    mul_b = rp2_q;      end
      MUL_KP_E:   begin mul_a = cfg_i.prop_gain; mul_b = err_q;      end
      MUL_KI_INT: begin mul_a = cfg_i.integ_gain; mul_b = integ_q;   end
      MUL_WG_EXC: begin mul_a = WgQ;             mul_b = acc_sat;    end
      default:    begin mul_a = '0;              mul_b = '0;         end
    endcase
  end

  assign prod_d = mul_a * mul_b;

  // Round to nearest with ties toward plus infinity: add one half, floor.
  assign rnd   = prod_q + 64'sd32768;
  assign q     = QW'(rnd >>> 16);
  assign q_ext = AccW'(q);

  always_comb begin
    unique case (ctl_i.acc)
      ACC_HOLD:    acc_d = acc_q;
      ACC_INT_Q:   acc_d = AccW'(integral_q) + q_ext;
      ACC_Q:       acc_d = q_ext;
      ACC_ADD_Q:   acc_d = acc_q + q_ext;
      ACC_SUB_Q:   acc_d = acc_q - q_ext;
      ACC_RES_Q:   acc_d = AccW'(acc_sat) + q_ext;
      ACC_ADD_FF:  acc_d = acc_q + AccW'(ff_q);
      ACC_SUB_OUT: acc_d = acc_q - AccW'(outv_q);
      default:     acc_d = acc_q;
    endcase
  end

  assign lim_ext = $signed({{(AccW-31){1'b0}}, cfg_i.integ_limit});

  always_comb begin
    integ_d    = integ_q;
    outv_d     = outv_q;
    clamped_d  = clamped_q;
    integral_d = integral_q;
    ep1_d      = ep1_q;
    ep2_d      = ep2_q;
    rp1_d      = rp1_q;
    rp2_d      = rp2_q;
    out_d      = out_q;
    unique case (ctl_i.act)
      ACT_NONE: begin
      end
      ACT_CLAMP_INT: begin
        priority if (acc_q > lim_ext) begin
          integ_d = 32'(lim_ext);
        end else if (acc_q < -lim_ext) begin
          integ_d = 32'(-lim_ext);
        end else begin
          integ_d = 32'(acc_q);
        end
      end
      ACT_SHIFT_HIST: begin
        ep2_d = ep1_q;
        ep1_d = err_q;
        rp2_d = rp1_q;
        rp1_d = acc_sat;
      end
      ACT_LIMIT_OUT: begin
        priority if (acc_q > AccW'(cfg_i.out_upper)) begin
          outv_d    = cfg_i.out_upper;
          clamped_d = 1'b1;
        end else if (acc_q < AccW'(cfg_i.out_lower)) begin
          outv_d    = cfg_i.out_lower;
          clamped_d = 1'b1;
        end else begin
          outv_d    = 32'(acc_q);
          clamped_d = 1'b0;
        end
      end
      ACT_FINISH: begin
        integral_d    = sat32(AccW'(integ_q) - q_ext);
        out_d.drive   = sat32(AccW'(outv_q) - q_ext);
        out_d.clamped = clamped_q;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.accept) begin
      err_q <= err_d;
      ff_q  <= in_data_i.feedforward_term;
    end
    if (ctl_i.mul != MUL_NONE) begin
      prod_q <= prod_d;
    end
    acc_q     <= acc_d;
    integ_q   <= integ_d;
    outv_q    <= outv_d;
    clamped_q <= clamped_d;
    out_q     <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integral_q <= '0;
      ep1_q      <= '0;
      ep2_q      <= '0;
      rp1_q      <= '0;
      rp2_q      <= '0;
    end else begin
      integral_q <= integral_d;
      ep1_q      <= ep1_d;
      ep2_q      <= ep2_d;
      rp1_q      <= rp1_d;
      rp2_q      <= rp2_d;
    end
  end

  assign out_data_o = out_q;

endmodule
